FILE: rtl/core/gtd_pkg.sv
// Shared constants, codes and types of the gang task dispatcher.
`timescale 1ns / 1ps
`default_nettype none
package gtd_pkg;

    localparam int CORES_DEF      = 64;
    localparam int MAX_SUB_DEF    = 32;
    localparam int QDEPTH_DEF     = 16;
    localparam int CMD_FIFO_DEPTH = 2;

    localparam int KIND_W = 3;
    localparam int STIME_W = 16;
    localparam int SUBS_W = 6;
    localparam int TIME_W = 32;
    localparam int BUSY_W = 21;
    localparam int FREE_W = 7;
    localparam int FIN_W = 7;
    localparam int PEND_W = 11;
    localparam int QLEN_W = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_TAKEN      = 3'd0,
        KIND_ENQUEUED   = 3'd1,
        KIND_REJECTED   = 3'd2,
        KIND_DISPATCHED = 3'd3,
        KIND_IDLE_TICK  = 3'd4
    } kind_t;

    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_SUBTASK = 1'b1
    } op_t;

    typedef struct packed {
        op_t                op;
        logic               pri;
        logic [STIME_W-1:0] stime;
        logic               last;
    } cmd_t;

    typedef struct packed {
        kind_t              kind;
        logic               task_priority;
        logic [SUBS_W-1:0]  task_subtasks;
        logic [TIME_W-1:0]  wait_ticks;
        logic [BUSY_W-1:0]  busy_added;
        logic [FREE_W-1:0]  free_cores;
        logic [FIN_W-1:0]   finished_subtasks;
        logic [PEND_W-1:0]  pending_subtasks;
        logic [QLEN_W-1:0]  queue_len_high;
        logic [QLEN_W-1:0]  queue_len_low;
        logic [TIME_W-1:0]  now;
        logic               last;
    } result_t;

endpackage
`default_nettype wire

FILE: rtl/core/gtd_ifs.sv
// Channel interfaces of the gang task dispatcher: subtask/tick items in, reports out.
`timescale 1ns / 1ps
`default_nettype none
interface gtd_in_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic                         priority_req;
    logic [gtd_pkg::STIME_W-1:0]  run_time;
    logic                         last_subtask;

    modport source (output valid, opcode, priority_req, run_time, last_subtask,
                     input ready);
    modport sink (input valid, opcode, priority_req, run_time, last_subtask,
                  output ready);
endinterface

interface gtd_out_if;
    logic                         valid;
    logic                         ready;
    logic [gtd_pkg::KIND_W-1:0]   kind;
    logic                         task_priority;
    logic [gtd_pkg::SUBS_W-1:0]   task_subtasks;
    logic [gtd_pkg::TIME_W-1:0]   wait_ticks;
    logic [gtd_pkg::BUSY_W-1:0]   busy_added;
    logic [gtd_pkg::FREE_W-1:0]   free_cores;
    logic [gtd_pkg::FIN_W-1:0]    finished_subtasks;
    logic [gtd_pkg::PEND_W-1:0]   pending_subtasks;
    logic [gtd_pkg::QLEN_W-1:0]   queue_len_high;
    logic [gtd_pkg::QLEN_W-1:0]   queue_len_low;
    logic [gtd_pkg::TIME_W-1:0]   now;
    logic                         last;

    modport source (output valid, kind, task_priority, task_subtasks, wait_ticks,
                     busy_added, free_cores, finished_subtasks, pending_subtasks,
                     queue_len_high, queue_len_low, now, last,
                     input ready);
    modport sink (input valid, kind, task_priority, task_subtasks, wait_ticks,
                  busy_added, free_cores, finished_subtasks, pending_subtasks,
                  queue_len_high, queue_len_low, now, last,
                  output ready);
    modport monitor (input valid, ready, kind, task_priority, task_subtasks, wait_ticks,
                     busy_added, free_cores, finished_subtasks, pending_subtasks,
                     queue_len_high, queue_len_low, now, last);
endinterface
`default_nettype wire

FILE: rtl/core/gtd_front.sv
// Front end: takes input beats, decodes them and holds them in a short command queue.
`timescale 1ns / 1ps
`default_nettype none
module gtd_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    gtd_in_if.sink             items,
    output gtd_pkg::cmd_t      cmd,
    output logic               cmd_valid,
    input  wire logic          cmd_ready
);

    localparam int PW = $clog2(gtd_pkg::CMD_FIFO_DEPTH);
    localparam int NW = $clog2(gtd_pkg::CMD_FIFO_DEPTH + 1);

    gtd_pkg::cmd_t fifo_reg [gtd_pkg::CMD_FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;

    gtd_pkg::cmd_t decoded;
    logic          push;
    logic          pop;

    always_comb
    begin
        decoded.op    = items.opcode ? gtd_pkg::OP_SUBTASK : gtd_pkg::OP_TICK;
        decoded.pri   = items.priority_req;
        // a zero service time still holds a core for one tick
        decoded.stime = (items.run_time == '0) ? gtd_pkg::STIME_W'(1)
                                               : items.run_time;
        decoded.last  = items.last_subtask;
    end

    assign items.ready = (count_reg != NW'(gtd_pkg::CMD_FIFO_DEPTH));
    assign push = items.valid && items.ready;
    assign cmd_valid = (count_reg != '0);
    assign cmd = fifo_reg[rd_ptr_reg];
    assign pop = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(gtd_pkg::CMD_FIFO_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(gtd_pkg::CMD_FIFO_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/gtd_back.sv
// Back end: job building, waiting queues, core pool, tick sequencer and report register.
`timescale 1ns / 1ps
`default_nettype none
module gtd_back
#(
    parameter int CORES        = gtd_pkg::CORES_DEF,
    parameter int MAX_SUBTASKS = gtd_pkg::MAX_SUB_DEF,
    parameter int QUEUE_DEPTH  = gtd_pkg::QDEPTH_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire gtd_pkg::cmd_t cmd,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    gtd_out_if.source          results
);

    localparam int SLOTS = 2 * QUEUE_DEPTH + 1;
    localparam int SW    = $clog2(SLOTS);
    localparam int KW    = (MAX_SUBTASKS > 1) ? $clog2(MAX_SUBTASKS) : 1;
    localparam int NW    = $clog2(MAX_SUBTASKS + 1);
    localparam int QW    = $clog2(QUEUE_DEPTH + 1);
    localparam int QIW   = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(CORES);
    localparam int FW    = $clog2(CORES + 1);
    localparam int RW    = $clog2(CORES + 1);
    localparam int TDEP  = SLOTS << KW;

    typedef struct packed {
        logic [SW-1:0]              slot;
        logic [gtd_pkg::TIME_W-1:0] stamp;
        logic [NW-1:0]              size;
    } entry_t;

    typedef struct packed {
        logic                       pri;
        logic [NW-1:0]              subs;
        logic [gtd_pkg::TIME_W-1:0] wait_t;
        logic [gtd_pkg::BUSY_W-1:0] busy;
    } rec_t;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_SERVE   = 9'b000000010,
        ST_FETCH   = 9'b000000100,
        ST_PLACE   = 9'b000001000,
        ST_RETIRE  = 9'b000010000,
        ST_CNT_RD  = 9'b000100000,
        ST_CNT_WR  = 9'b001000000,
        ST_EMIT_RD = 9'b010000000,
        ST_EMIT    = 9'b100000000
    } state_t;

    // memories
    logic [gtd_pkg::STIME_W-1:0] times_mem [TDEP];
    logic [gtd_pkg::STIME_W-1:0] core_mem  [CORES];
    rec_t                        rec_mem   [CORES];

    state_t state_reg, state_next;
    entry_t list_reg [2][QUEUE_DEPTH];
    entry_t list_next [2][QUEUE_DEPTH];
    logic [QW-1:0] qcount_reg [2];
    logic [QW-1:0] qcount_next [2];
    logic [SLOTS-1:0] used_reg, used_next;
    logic [CORES-1:0] idle_reg, idle_next;
    logic [gtd_pkg::TIME_W-1:0] tick_reg, tick_next;
    logic [gtd_pkg::PEND_W-1:0] pend_reg, pend_next;
    logic [FW-1:0] free_reg, free_next;
    logic [NW-1:0] bcount_reg, bcount_next;
    logic bpri_reg, bpri_next;
    logic bovf_reg, bovf_next;
    logic [SW-1:0] bslot_reg, bslot_next;

    logic p_reg, p_next;
    logic [QW-1:0] i_reg, i_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [NW-1:0] need_reg, need_next;
    logic [NW-1:0] k_reg, k_next;
    logic [CW-1:0] c_reg, c_next;
    logic [gtd_pkg::BUSY_W-1:0] busy_reg, busy_next;
    logic [gtd_pkg::TIME_W-1:0] wait_reg, wait_next;
    logic [RW-1:0] recn_reg, recn_next;
    logic [RW-1:0] e_reg, e_next;
    logic [gtd_pkg::FIN_W-1:0] fin_reg, fin_next;
    logic [gtd_pkg::TIME_W-1:0] nowt_reg, nowt_next;

    logic [gtd_pkg::STIME_W-1:0] time_rd_reg;
    logic [gtd_pkg::STIME_W-1:0] core_rd_reg;
    rec_t                        rec_rd_reg;

    logic out_valid_reg, out_valid_next;
    gtd_pkg::result_t out_reg, out_next;
    logic out_free;

    // write and read controls for the memories
    logic times_we;
    logic [SW+KW-1:0] times_waddr;
    logic [SW+KW-1:0] times_raddr;
    logic core_we;
    logic [gtd_pkg::STIME_W-1:0] core_wdata;
    logic rec_we;
    rec_t rec_wdata;

    logic [SW-1:0] free_slot;
    entry_t cur;
    logic first;
    logic pri_eff;
    logic [SW-1:0] slot_eff;
    logic [NW-1:0] cnt_new;
    logic ovf_new;
    logic [gtd_pkg::STIME_W-1:0] dec_val;
    logic last_core;

    assign out_free = !out_valid_reg || results.ready;
    assign last_core = (c_reg == CW'(CORES - 1));
    assign cur = list_reg[p_reg][i_reg[QIW-1:0]];
    assign dec_val = core_rd_reg - 1'b1;
    assign times_raddr = {slot_reg, k_reg[KW-1:0]};

    always_comb
    begin
        free_slot = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (!used_reg[s])
            begin
                free_slot = SW'(s);
            end
        end
    end

    always_comb
    begin
        first    = (bcount_reg == '0) && !bovf_reg;
        pri_eff  = first ? cmd.pri : bpri_reg;
        slot_eff = first ? free_slot : bslot_reg;
        ovf_new  = bovf_reg || (bcount_reg >= NW'(MAX_SUBTASKS));
        cnt_new  = (bcount_reg < NW'(MAX_SUBTASKS)) ? bcount_reg + 1'b1 : bcount_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        list_next   = list_reg;
        qcount_next = qcount_reg;
        used_next   = used_reg;
        idle_next   = idle_reg;
        tick_next   = tick_reg;
        pend_next   = pend_reg;
        free_next   = free_reg;
        bcount_next = bcount_reg;
        bpri_next   = bpri_reg;
        bovf_next   = bovf_reg;
        bslot_next  = bslot_reg;
        p_next      = p_reg;
        i_next      = i_reg;
        slot_next   = slot_reg;
        need_next   = need_reg;
        k_next      = k_reg;
        c_next      = c_reg;
        busy_next   = busy_reg;
        wait_next   = wait_reg;
        recn_next   = recn_reg;
        e_next      = e_reg;
        fin_next    = fin_reg;
        nowt_next   = nowt_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_next    = out_reg;
        cmd_ready   = 1'b0;
        times_we    = 1'b0;
        times_waddr = {slot_eff, bcount_reg[KW-1:0]};
        core_we     = 1'b0;
        core_wdata  = time_rd_reg;
        rec_we      = 1'b0;
        rec_wdata   = '{pri: p_reg, subs: need_reg, wait_t: wait_reg, busy: busy_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && cmd.op == gtd_pkg::OP_TICK)
                begin
                    cmd_ready  = 1'b1;
                    p_next     = 1'b0;
                    i_next     = '0;
                    recn_next  = '0;
                    fin_next   = '0;
                    nowt_next  = tick_reg;
                    state_next = ST_SERVE;
                end
                else if (cmd_valid && out_free)
                begin
                    cmd_ready = 1'b1;
                    times_we  = (bcount_reg < NW'(MAX_SUBTASKS));
                    out_next.kind = gtd_pkg::KIND_TAKEN;
                    if (cmd.last)
                    begin
                        if (ovf_new || qcount_reg[pri_eff] >= QW'(QUEUE_DEPTH))
                        begin
                            out_next.kind = gtd_pkg::KIND_REJECTED;
                        end
                        else
                        begin
                            list_next[pri_eff][qcount_reg[pri_eff][QIW-1:0]] =
                                '{slot: slot_eff, stamp: tick_reg, size: cnt_new};
                            qcount_next[pri_eff] = qcount_reg[pri_eff] + 1'b1;
                            used_next[slot_eff]  = 1'b1;
                            pend_next = pend_reg + gtd_pkg::PEND_W'(cnt_new);
                            out_next.kind = gtd_pkg::KIND_ENQUEUED;
                        end
                        bcount_next = '0;
                        bpri_next   = 1'b0;
                        bovf_next   = 1'b0;
                    end
                    else
                    begin
                        bcount_next = cnt_new;
                        bpri_next   = pri_eff;
                        bovf_next   = ovf_new;
                        bslot_next  = slot_eff;
                    end
                    out_valid_next = 1'b1;
                    out_next.task_priority     = pri_eff;
                    out_next.task_subtasks     = gtd_pkg::SUBS_W'(cnt_new);
                    out_next.wait_ticks        = '0;
                    out_next.busy_added        = '0;
                    out_next.free_cores        = gtd_pkg::FREE_W'(free_reg);
                    out_next.finished_subtasks = '0;
                    out_next.pending_subtasks  = pend_next;
                    out_next.queue_len_high    = gtd_pkg::QLEN_W'(qcount_next[0]);
                    out_next.queue_len_low     = gtd_pkg::QLEN_W'(qcount_next[1]);
                    out_next.now               = tick_reg;
                    out_next.last              = 1'b1;
                end
            end

            ST_SERVE:
            begin
                if (i_reg < qcount_reg[p_reg])
                begin
                    if (cur.size <= free_reg)
                    begin
                        slot_next  = cur.slot;
                        need_next  = cur.size;
                        k_next     = '0;
                        c_next     = '0;
                        busy_next  = '0;
                        wait_next  = nowt_reg - cur.stamp;
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else if (!p_reg && qcount_reg[0] == '0)
                begin
                    p_next = 1'b1;
                    i_next = '0;
                end
                else
                begin
                    c_next     = '0;
                    state_next = ST_CNT_RD;
                end
            end

            ST_FETCH:
            begin
                state_next = ST_PLACE;
            end

            ST_PLACE:
            begin
                c_next = c_reg + 1'b1;
                if (idle_reg[c_reg])
                begin
                    core_we          = 1'b1;
                    idle_next[c_reg] = 1'b0;
                    free_next        = free_reg - 1'b1;
                    busy_next        = busy_reg + gtd_pkg::BUSY_W'(time_rd_reg);
                    k_next           = k_reg + 1'b1;
                    state_next       = ((k_reg + NW'(1)) == need_reg) ? ST_RETIRE : ST_FETCH;
                end
            end

            ST_RETIRE:
            begin
                rec_we    = 1'b1;
                recn_next = recn_reg + 1'b1;
                // close the gap left by the dispatched job
                for (int j = 0; j < QUEUE_DEPTH - 1; j++)
                begin
                    if (QW'(j) >= i_reg)
                    begin
                        list_next[p_reg][j] = list_reg[p_reg][j + 1];
                    end
                end
                qcount_next[p_reg] = qcount_reg[p_reg] - 1'b1;
                used_next[slot_reg] = 1'b0;
                state_next = ST_SERVE;
            end

            ST_CNT_RD:
            begin
                if (idle_reg[c_reg])
                begin
                    if (last_core)
                    begin
                        tick_next  = tick_reg + 1'b1;
                        e_next     = '0;
                        state_next = ST_EMIT_RD;
                    end
                    else
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_CNT_WR;
                end
            end

            ST_CNT_WR:
            begin
                core_we    = 1'b1;
                core_wdata = dec_val;
                if (dec_val == '0)
                begin
                    idle_next[c_reg] = 1'b1;
                    fin_next  = fin_reg + 1'b1;
                    free_next = free_reg + 1'b1;
                    if (pend_reg != '0)
                    begin
                        pend_next = pend_reg - 1'b1;
                    end
                end
                if (last_core)
                begin
                    tick_next  = tick_reg + 1'b1;
                    e_next     = '0;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    c_next     = c_reg + 1'b1;
                    state_next = ST_CNT_RD;
                end
            end

            ST_EMIT_RD:
            begin
                if (recn_reg == '0)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_next.kind              = gtd_pkg::KIND_IDLE_TICK;
                        out_next.task_priority     = 1'b0;
                        out_next.task_subtasks     = '0;
                        out_next.wait_ticks        = '0;
                        out_next.busy_added        = '0;
                        out_next.free_cores        = gtd_pkg::FREE_W'(free_reg);
                        out_next.finished_subtasks = fin_reg;
                        out_next.pending_subtasks  = pend_reg;
                        out_next.queue_len_high    = gtd_pkg::QLEN_W'(qcount_reg[0]);
                        out_next.queue_len_low     = gtd_pkg::QLEN_W'(qcount_reg[1]);
                        out_next.now               = nowt_reg;
                        out_next.last              = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next.kind              = gtd_pkg::KIND_DISPATCHED;
                    out_next.task_priority     = rec_rd_reg.pri;
                    out_next.task_subtasks     = gtd_pkg::SUBS_W'(rec_rd_reg.subs);
                    out_next.wait_ticks        = rec_rd_reg.wait_t;
                    out_next.busy_added        = rec_rd_reg.busy;
                    out_next.free_cores        = gtd_pkg::FREE_W'(free_reg);
                    out_next.pending_subtasks  = pend_reg;
                    out_next.queue_len_high    = gtd_pkg::QLEN_W'(qcount_reg[0]);
                    out_next.queue_len_low     = gtd_pkg::QLEN_W'(qcount_reg[1]);
                    out_next.now               = nowt_reg;
                    out_next.last              = ((e_reg + RW'(1)) == recn_reg);
                    out_next.finished_subtasks = out_next.last ? fin_reg : '0;
                    e_next     = e_reg + 1'b1;
                    state_next = out_next.last ? ST_IDLE : ST_EMIT_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            qcount_reg[0] <= '0;
            qcount_reg[1] <= '0;
            used_reg      <= '0;
            idle_reg      <= '1;
            tick_reg      <= '0;
            pend_reg      <= '0;
            free_reg      <= FW'(CORES);
            bcount_reg    <= '0;
            bpri_reg      <= 1'b0;
            bovf_reg      <= 1'b0;
            p_reg         <= 1'b0;
            i_reg         <= '0;
            k_reg         <= '0;
            c_reg         <= '0;
            recn_reg      <= '0;
            e_reg         <= '0;
            fin_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            qcount_reg    <= qcount_next;
            used_reg      <= used_next;
            idle_reg      <= idle_next;
            tick_reg      <= tick_next;
            pend_reg      <= pend_next;
            free_reg      <= free_next;
            bcount_reg    <= bcount_next;
            bpri_reg      <= bpri_next;
            bovf_reg      <= bovf_next;
            p_reg         <= p_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            c_reg         <= c_next;
            recn_reg      <= recn_next;
            e_reg         <= e_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        list_reg  <= list_next;
        bslot_reg <= bslot_next;
        slot_reg  <= slot_next;
        need_reg  <= need_next;
        busy_reg  <= busy_next;
        wait_reg  <= wait_next;
        nowt_reg  <= nowt_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (times_we)
        begin
            times_mem[times_waddr] <= cmd.stime;
        end
        if (state_reg == ST_FETCH)
        begin
            time_rd_reg <= times_mem[times_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_we)
        begin
            core_mem[c_reg] <= core_wdata;
        end
        if (state_reg == ST_CNT_RD)
        begin
            core_rd_reg <= core_mem[c_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[recn_reg[CW-1:0]] <= rec_wdata;
        end
        if (state_reg == ST_EMIT_RD)
        begin
            rec_rd_reg <= rec_mem[e_reg[CW-1:0]];
        end
    end

    assign results.valid             = out_valid_reg;
    assign results.kind              = out_reg.kind;
    assign results.task_priority     = out_reg.task_priority;
    assign results.task_subtasks     = out_reg.task_subtasks;
    assign results.wait_ticks        = out_reg.wait_ticks;
    assign results.busy_added        = out_reg.busy_added;
    assign results.free_cores        = out_reg.free_cores;
    assign results.finished_subtasks = out_reg.finished_subtasks;
    assign results.pending_subtasks  = out_reg.pending_subtasks;
    assign results.queue_len_high    = out_reg.queue_len_high;
    assign results.queue_len_low     = out_reg.queue_len_low;
    assign results.now               = out_reg.now;
    assign results.last              = out_reg.last;

endmodule
`default_nettype wire

FILE: rtl/core/gang_task_dispatcher.sv
// Top level of the gang task dispatcher: front end, command queue and back end.
// A subtask beat's report is registered when the beat leaves the two-entry command
// queue. A tick is run by one sequencer over the core pool: it checks each waiting
// job in turn, switches to the low-priority queue once the high-priority one is
// empty, places each dispatched job subtask by subtask (a read of the service time
// store, then a core visit that passes over busy cores) and then retires it; the
// countdown then visits every core, with a core store read and write for a busy one;
// each dispatch report needs a read of the record store before it is sent, and a
// tick without dispatch sends one idle-tick report. There is no clearing pass after
// reset; the block takes beats at once.
`timescale 1ns / 1ps
`default_nettype none
module gang_task_dispatcher
#(
    parameter int CORES        = gtd_pkg::CORES_DEF,
    parameter int MAX_SUBTASKS = gtd_pkg::MAX_SUB_DEF,
    parameter int QUEUE_DEPTH  = gtd_pkg::QDEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    gtd_in_if.sink    items,
    gtd_out_if.source results
);

    gtd_pkg::cmd_t cmd;
    logic          cmd_valid;
    logic          cmd_ready;

    gtd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready)
    );

    gtd_back
    #(
        .CORES        (CORES),
        .MAX_SUBTASKS (MAX_SUBTASKS),
        .QUEUE_DEPTH  (QUEUE_DEPTH)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .results   (results)
    );

endmodule
`default_nettype wire

FILE: rtl/core/gtd_checker.sv
// Port-level checks on the report channel of the gang task dispatcher, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module gtd_checker
#(
    parameter int CORES       = gtd_pkg::CORES_DEF,
    parameter int QUEUE_DEPTH = gtd_pkg::QDEPTH_DEF
)
(
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        valid,
    input wire logic                        ready,
    input wire logic [gtd_pkg::KIND_W-1:0]  kind,
    input wire logic [gtd_pkg::SUBS_W-1:0]  task_subtasks,
    input wire logic [gtd_pkg::BUSY_W-1:0]  busy_added,
    input wire logic [gtd_pkg::FREE_W-1:0]  free_cores,
    input wire logic [gtd_pkg::FIN_W-1:0]   finished_subtasks,
    input wire logic [gtd_pkg::QLEN_W-1:0]  queue_len_high,
    input wire logic [gtd_pkg::QLEN_W-1:0]  queue_len_low,
    input wire logic                        last
);

    // hold a stalled beat
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("report beat dropped while stalled");

    // subtask and idle-tick reports stand alone
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && kind != gtd_pkg::KIND_DISPATCHED |-> last)
        else $error("single report not marked last");

    // finished count only on the closing report of a tick
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last |-> finished_subtasks == '0)
        else $error("finished count on an inner report");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> queue_len_high <= QUEUE_DEPTH
               && queue_len_low <= QUEUE_DEPTH
               && free_cores <= CORES)
        else $error("queue length or free core count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid && kind == gtd_pkg::KIND_IDLE_TICK
            |-> task_subtasks == '0 && busy_added == '0)
        else $error("idle tick carries a job");

endmodule

bind gang_task_dispatcher gtd_checker
#(
    .CORES       (CORES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
)
u_gtd_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .valid             (results.valid),
    .ready             (results.ready),
    .kind              (results.kind),
    .task_subtasks     (results.task_subtasks),
    .busy_added        (results.busy_added),
    .free_cores        (results.free_cores),
    .finished_subtasks (results.finished_subtasks),
    .queue_len_high    (results.queue_len_high),
    .queue_len_low     (results.queue_len_low),
    .last              (results.last)
);
`default_nettype wire
